/* src/dtq_pkg.sv */
// dtq_pkg: shared types and constants of the due time task queue
// holds slot count default, field widths, item kinds, status codes and states
// no dependencies
package dtq_pkg;

   localparam int SLOTS_DEF = 64;

   localparam int VOL_W    = 64;
   localparam int TIME_W   = 40;
   localparam int RET_W    = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int QCOUNT_W = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD     = 2'd0,
      KIND_REMOVE  = 2'd1,
      KIND_TICK    = 2'd2,
      KIND_RESCHED = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INSERTED  = 3'd0,
      STAT_KEPT      = 3'd1,
      STAT_FOREVER   = 3'd2,
      STAT_REMOVED   = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_FULL      = 3'd5,
      STAT_DROPPED   = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [VOL_W-1:0]  volume;
      logic [TIME_W-1:0] deadline;
   } entry_type;

endpackage

/* src/dtq_ram.sv */
// dtq_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module dtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/due_time_task_queue_top.sv */
// due_time_task_queue_top: earliest deadline table of per-volume due times
// uses dtq_pkg and one dtq_ram holding valid, volume and deadline per slot
//
//   channel | ports  | direction | payload
//   --------+--------+-----------+-------------------------------------------------
//   request | req_*  | in        | kind, volume_id, creation_time, retention, times
//   result  | rsp_*  | out       | ok, status, due_valid, due_volume, earliest, count
//
// each beat runs accept, then one read per slot through the single ram read port
// with registered read data, then a write-back
// after reset a clearing pass writes every slot, req_stall held high
// req_stall is high from accept through the write-back, and the write-back waits
// while a previous result is still stalled in the output register
module due_time_task_queue_top #(
   parameter int SLOTS = dtq_pkg::SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dtq_pkg::KIND_W-1:0]    req_kind,
   input  logic [dtq_pkg::VOL_W-1:0]     req_volume_id,
   input  logic [dtq_pkg::TIME_W-1:0]    req_creation_time,
   input  logic signed [dtq_pkg::RET_W-1:0] req_retention_seconds,
   input  logic [dtq_pkg::TIME_W-1:0]    req_current_time,
   input  logic [dtq_pkg::TIME_W-1:0]    req_next_time,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic [dtq_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_due_valid,
   output logic [dtq_pkg::VOL_W-1:0]     rsp_due_volume,
   output logic [dtq_pkg::TIME_W-1:0]    rsp_earliest_time,
   output logic [dtq_pkg::QCOUNT_W-1:0]  rsp_queued_count
);

   localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW     = $clog2(SLOTS + 1);
   localparam int TW     = dtq_pkg::TIME_W;
   localparam int VW     = dtq_pkg::VOL_W;
   localparam int WORD_W = $bits(dtq_pkg::entry_type);

   // control state
   dtq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // item registers
   dtq_pkg::kind_type  kind_ff, kind_in;
   logic [VW-1:0]      vol_ff, vol_in;
   logic [TW-1:0]      now_ff, now_in;
   logic [TW-1:0]      next_ff, next_in;
   logic [TW-1:0]      dl_ff, dl_in;
   logic               pos_ff, pos_in;
   logic               keep_ff, keep_in;

   // scan results
   logic               found_ff, found_in;
   logic [AW-1:0]      match_idx_ff, match_idx_in;
   logic               match_keep_ff, match_keep_in;
   logic [TW-1:0]      match_dl_ff, match_dl_in;
   logic               free_found_ff, free_found_in;
   logic [AW-1:0]      free_idx_ff, free_idx_in;
   logic               best_found_ff, best_found_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [TW-1:0]      best_dl_ff, best_dl_in;
   logic [VW-1:0]      best_vol_ff, best_vol_in;

   // result registers
   logic                          rsp_ok_ff, rsp_ok_in;
   logic [dtq_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                          rsp_due_ff, rsp_due_in;
   logic [VW-1:0]                 rsp_vol_ff, rsp_vol_in;
   logic [TW-1:0]                 rsp_time_ff, rsp_time_in;
   logic [dtq_pkg::QCOUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // ram ports
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   dtq_pkg::entry_type  ram_wdata;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   logic [WORD_W-1:0]   ram_rdata;
   dtq_pkg::entry_type  rd_entry;

   logic               req_take;
   logic               out_free;
   logic               scan_last;
   logic               mod_en;
   logic               is_match;
   logic               eff_valid;
   logic [TW-1:0]      eff_dl;
   logic [TW:0]        dl_sum;
   logic               ins;
   logic               drop;
   logic               wr_pending;
   logic               new_best;

   dtq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_entry  = dtq_pkg::entry_type'(ram_rdata);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_last = rd_vld_ff && (rd_idx_ff == AW'(SLOTS - 1));

   assign dl_sum = {1'b0, req_creation_time}
                 + {{(TW + 1 - (dtq_pkg::RET_W - 1)){1'b0}},
                    req_retention_seconds[dtq_pkg::RET_W-2:0]};

   assign mod_en = ((kind_ff == dtq_pkg::KIND_ADD) && pos_ff)
                || (kind_ff inside {dtq_pkg::KIND_REMOVE, dtq_pkg::KIND_RESCHED});

   // per-slot view after this item's change
   always_comb begin
      is_match  = rd_vld_ff && rd_entry.valid && mod_en && !found_ff
               && (rd_entry.volume == vol_ff);
      eff_valid = rd_entry.valid;
      eff_dl    = rd_entry.deadline;
      if (is_match) begin
         case (kind_ff)
            dtq_pkg::KIND_ADD: begin
               if (dl_ff < rd_entry.deadline) begin
                  eff_dl = dl_ff;
               end
            end
            dtq_pkg::KIND_REMOVE: begin
               eff_valid = 1'b0;
            end
            dtq_pkg::KIND_RESCHED: begin
               eff_valid = keep_ff;
               eff_dl    = next_ff;
            end
            default: begin
               eff_valid = rd_entry.valid;
            end
         endcase
      end
   end

   // final decision in the write-back cycle
   always_comb begin
      ins  = (kind_ff == dtq_pkg::KIND_ADD) && pos_ff && !found_ff && free_found_ff;
      drop = found_ff && ((kind_ff == dtq_pkg::KIND_REMOVE)
                       || ((kind_ff == dtq_pkg::KIND_RESCHED) && !keep_ff));
      wr_pending = ins || (found_ff && mod_en);
      new_best = ins && (!best_found_ff || (dl_ff < best_dl_ff)
                 || ((dl_ff == best_dl_ff) && (free_idx_ff < best_idx_ff)));
      count_in = count_ff;
      if (state_ff == dtq_pkg::ST_WRITE && out_free) begin
         if (ins) begin
            count_in = count_ff + CW'(1);
         end else if (drop) begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   always_comb begin
      rsp_ok_in     = 1'b0;
      rsp_status_in = dtq_pkg::STAT_INSERTED;
      rsp_due_in    = 1'b0;
      case (kind_ff)
         dtq_pkg::KIND_ADD: begin
            if (!pos_ff) begin
               rsp_ok_in     = 1'b1;
               rsp_status_in = dtq_pkg::STAT_FOREVER;
            end else if (found_ff) begin
               rsp_status_in = dtq_pkg::STAT_KEPT;
            end else if (free_found_ff) begin
               rsp_ok_in     = 1'b1;
               rsp_status_in = dtq_pkg::STAT_INSERTED;
            end else begin
               rsp_status_in = dtq_pkg::STAT_FULL;
            end
         end
         dtq_pkg::KIND_REMOVE: begin
            rsp_ok_in     = found_ff;
            rsp_status_in = found_ff ? dtq_pkg::STAT_REMOVED : dtq_pkg::STAT_NOT_FOUND;
         end
         dtq_pkg::KIND_RESCHED: begin
            rsp_ok_in = found_ff;
            if (!found_ff) begin
               rsp_status_in = dtq_pkg::STAT_NOT_FOUND;
            end else if (keep_ff) begin
               rsp_status_in = dtq_pkg::STAT_KEPT;
            end else begin
               rsp_status_in = dtq_pkg::STAT_DROPPED;
            end
         end
         dtq_pkg::KIND_TICK: begin
            rsp_due_in = best_found_ff && (best_dl_ff <= now_ff);
         end
         default: begin
            rsp_ok_in = 1'b0;
         end
      endcase
      if (new_best) begin
         rsp_vol_in  = vol_ff;
         rsp_time_in = dl_ff;
      end else if (best_found_ff) begin
         rsp_vol_in  = best_vol_ff;
         rsp_time_in = best_dl_ff;
      end else begin
         rsp_vol_in  = '0;
         rsp_time_in = '0;
      end
      rsp_count_in = dtq_pkg::QCOUNT_W'(count_in);
      if (state_ff == dtq_pkg::ST_WRITE && out_free) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // item capture and scan bookkeeping
   always_comb begin
      kind_in       = kind_ff;
      vol_in        = vol_ff;
      now_in        = now_ff;
      next_in       = next_ff;
      dl_in         = dl_ff;
      pos_in        = pos_ff;
      keep_in       = keep_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      match_keep_in = match_keep_ff;
      match_dl_in   = match_dl_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_vol_in   = best_vol_ff;
      if (req_take) begin
         kind_in       = dtq_pkg::kind_type'(req_kind);
         vol_in        = req_volume_id;
         now_in        = req_current_time;
         next_in       = req_next_time;
         dl_in         = dl_sum[TW] ? {TW{1'b1}} : dl_sum[TW-1:0];
         pos_in        = (req_retention_seconds > 0);
         keep_in       = (req_next_time > req_current_time);
         found_in      = 1'b0;
         free_found_in = 1'b0;
         best_found_in = 1'b0;
      end else if (state_ff == dtq_pkg::ST_SCAN && rd_vld_ff) begin
         if (is_match) begin
            found_in      = 1'b1;
            match_idx_in  = rd_idx_ff;
            match_keep_in = eff_valid;
            match_dl_in   = eff_dl;
         end
         if (!rd_entry.valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
         if (eff_valid && (!best_found_ff || (eff_dl < best_dl_ff))) begin
            best_found_in = 1'b1;
            best_idx_in   = rd_idx_ff;
            best_dl_in    = eff_dl;
            best_vol_in   = rd_entry.volume;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtq_pkg::ST_CLEAR: begin
            if (cnt_ff == CW'(SLOTS - 1)) begin
               state_in = dtq_pkg::ST_IDLE;
            end
         end
         dtq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dtq_pkg::ST_SCAN;
            end
         end
         dtq_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = dtq_pkg::ST_WRITE;
            end
         end
         dtq_pkg::ST_WRITE: begin
            if (out_free) begin
               state_in = dtq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtq_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and ram control
   always_comb begin
      req_stall = 1'b1;
      ram_we    = 1'b0;
      ram_waddr = cnt_ff[AW-1:0];
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = cnt_ff[AW-1:0];
      cnt_in    = cnt_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      case (state_ff)
         dtq_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + CW'(1);
         end
         dtq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cnt_in    = '0;
         end
         dtq_pkg::ST_SCAN: begin
            if (cnt_ff < CW'(SLOTS)) begin
               ram_re    = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[AW-1:0];
               cnt_in    = cnt_ff + CW'(1);
            end
         end
         dtq_pkg::ST_WRITE: begin
            ram_we = out_free && wr_pending;
            if (ins) begin
               ram_waddr          = free_idx_ff;
               ram_wdata.valid    = 1'b1;
               ram_wdata.volume   = vol_ff;
               ram_wdata.deadline = dl_ff;
            end else begin
               ram_waddr          = match_idx_ff;
               ram_wdata.valid    = match_keep_ff;
               ram_wdata.volume   = vol_ff;
               ram_wdata.deadline = match_dl_ff;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtq_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      kind_ff       <= kind_in;
      vol_ff        <= vol_in;
      now_ff        <= now_in;
      next_ff       <= next_in;
      dl_ff         <= dl_in;
      pos_ff        <= pos_in;
      keep_ff       <= keep_in;
      found_ff      <= found_in;
      match_idx_ff  <= match_idx_in;
      match_keep_ff <= match_keep_in;
      match_dl_ff   <= match_dl_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_dl_ff    <= best_dl_in;
      best_vol_ff   <= best_vol_in;
      if (state_ff == dtq_pkg::ST_WRITE && out_free) begin
         rsp_ok_ff     <= rsp_ok_in;
         rsp_status_ff <= rsp_status_in;
         rsp_due_ff    <= rsp_due_in;
         rsp_vol_ff    <= rsp_vol_in;
         rsp_time_ff   <= rsp_time_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_due_valid     = rsp_due_ff;
   assign rsp_due_volume    = rsp_vol_ff;
   assign rsp_earliest_time = rsp_time_ff;
   assign rsp_queued_count  = rsp_count_ff;

endmodule

/* tb/tb_due_time_task_queue_top.sv */
// tb_due_time_task_queue_top: self-checking bench for the earliest deadline volume table
// directed rows then three random phases, each result checked against a preset row or a local predictor
// depends on dtq_pkg and due_time_task_queue_top
`timescale 1ns / 100ps

module tb_due_time_task_queue_top;

   localparam int NSLOTS         = dtq_pkg::SLOTS_DEF;
   localparam int VOL_W          = dtq_pkg::VOL_W;
   localparam int TIME_W         = dtq_pkg::TIME_W;
   localparam int RET_W          = dtq_pkg::RET_W;
   localparam int KIND_W         = dtq_pkg::KIND_W;
   localparam int STATUS_W       = dtq_pkg::STATUS_W;
   localparam int QCOUNT_W       = dtq_pkg::QCOUNT_W;
   localparam int POOL_SIZE      = 96;
   localparam int HOLD_CYCLES    = 400;
   localparam int TIMEOUT_CYCLES = 3000;
   localparam int NUM_DIRECTED   = 24;

   localparam logic [VOL_W-1:0]  VOL_ONES = '1;
   localparam logic [VOL_W-1:0]  VOL_A    = 64'h5555_5555_5555_5555;
   localparam logic [VOL_W-1:0]  VOL_B    = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [TIME_W-1:0] TIME_MID = 40'd1_000_000;
   localparam logic [RET_W-1:0]  RET_MAX  = 32'h7FFF_FFFF;
   localparam logic [RET_W-1:0]  RET_MIN  = 32'h8000_0000;
   localparam logic [RET_W-1:0]  RET_ONES = '1;

   typedef struct packed {
      dtq_pkg::kind_type kind;
      logic [VOL_W-1:0]  volume;
      logic [TIME_W-1:0] created;
      logic [RET_W-1:0]  retention;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] next;
   } vol_op_type;

   typedef struct packed {
      logic                ok;
      dtq_pkg::status_type status;
      logic                due;
      logic [VOL_W-1:0]    volume;
      logic [TIME_W-1:0]   earliest;
      logic [QCOUNT_W-1:0] count;
   } vol_result_type;

   typedef struct packed {
      vol_op_type     op;
      logic           has_preset;
      vol_result_type preset;
   } vol_step_type;

   localparam vol_result_type NO_RESULT   = '0;
   localparam vol_result_type RES_EMPTY   =
      '{1'b0, dtq_pkg::STAT_INSERTED, 1'b0, 64'd0, 40'd0, 7'd0};
   localparam vol_result_type RES_MISSING =
      '{1'b0, dtq_pkg::STAT_NOT_FOUND, 1'b0, 64'd0, 40'd0, 7'd0};
   localparam vol_result_type RES_FOREVER =
      '{1'b1, dtq_pkg::STAT_FOREVER, 1'b0, 64'd0, 40'd0, 7'd0};

   localparam vol_step_type DIRECTED [NUM_DIRECTED] = '{
      '{'{dtq_pkg::KIND_TICK, 64'd0, 40'd0, 32'd0, 40'd0, 40'd0}, 1'b1, RES_EMPTY},
      '{'{dtq_pkg::KIND_REMOVE, 64'd0, TIME_MAX, RET_ONES, TIME_MAX, TIME_MAX}, 1'b1,
        RES_MISSING},
      '{'{dtq_pkg::KIND_RESCHED, VOL_ONES, 40'd0, 32'd0, 40'd0, 40'd5}, 1'b1, RES_MISSING},
      '{'{dtq_pkg::KIND_ADD, VOL_A, 40'd5, 32'd0, 40'd0, 40'd0}, 1'b1, RES_FOREVER},
      '{'{dtq_pkg::KIND_ADD, VOL_A, 40'd5, RET_MIN, 40'd0, 40'd0}, 1'b1, RES_FOREVER},
      '{'{dtq_pkg::KIND_ADD, VOL_A, 40'd5, RET_ONES, 40'd0, 40'd0}, 1'b1, RES_FOREVER},
      '{'{dtq_pkg::KIND_ADD, VOL_ONES, TIME_MAX, RET_MAX, 40'd0, 40'd0}, 1'b1,
        '{1'b1, dtq_pkg::STAT_INSERTED, 1'b0, VOL_ONES, TIME_MAX, 7'd1}},
      '{'{dtq_pkg::KIND_ADD, 64'd0, 40'd0, 32'd1, 40'd0, 40'd0}, 1'b1,
        '{1'b1, dtq_pkg::STAT_INSERTED, 1'b0, 64'd0, 40'd1, 7'd2}},
      '{'{dtq_pkg::KIND_ADD, 64'd0, 40'd0, 32'd5, 40'd0, 40'd0}, 1'b0, NO_RESULT},
      '{'{dtq_pkg::KIND_ADD, VOL_A, 40'd100, 32'd1, 40'd0, 40'd0}, 1'b0, NO_RESULT},
      '{'{dtq_pkg::KIND_ADD, VOL_B, 40'd0, 32'd1, 40'd0, 40'd0}, 1'b0, NO_RESULT},
      '{'{dtq_pkg::KIND_TICK, VOL_ONES, TIME_MAX, RET_ONES, 40'd0, TIME_MAX}, 1'b0,
        NO_RESULT},
      '{'{dtq_pkg::KIND_TICK, 64'd0, 40'd0, 32'd0, 40'd1, 40'd0}, 1'b0, NO_RESULT},
      '{'{dtq_pkg::KIND_ADD, VOL_A, 40'd0, 32'd1, 40'd0, 40'd0}, 1'b0, NO_RESULT},
      '{'{dtq_pkg::KIND_ADD, VOL_A, 40'd0, 32'd1, 40'd0, 40'd0}, 1'b0, NO_RESULT},
      '{'{dtq_pkg::KIND_REMOVE, 64'd0, 40'd0, 32'd0, 40'd0, 40'd0}, 1'b0, NO_RESULT},
      '{'{dtq_pkg::KIND_RESCHED, VOL_A, 40'd0, 32'd0, 40'd10, 40'd10}, 1'b0, NO_RESULT},
      '{'{dtq_pkg::KIND_RESCHED, VOL_B, 40'd0, 32'd0, 40'd5, TIME_MAX}, 1'b0, NO_RESULT},
      '{'{dtq_pkg::KIND_TICK, 64'd0, 40'd0, 32'd0, 40'hFF_FFFF_FFFE, 40'd0}, 1'b0,
        NO_RESULT},
      '{'{dtq_pkg::KIND_TICK, 64'd0, 40'd0, 32'd0, TIME_MAX, 40'd0}, 1'b0, NO_RESULT},
      '{'{dtq_pkg::KIND_RESCHED, VOL_B, 40'd0, 32'd0, TIME_MAX, 40'd0}, 1'b0, NO_RESULT},
      '{'{dtq_pkg::KIND_REMOVE, VOL_ONES, 40'd0, 32'd0, 40'd0, 40'd0}, 1'b0, NO_RESULT},
      '{'{dtq_pkg::KIND_TICK, 64'd0, 40'd0, 32'd0, TIME_MAX, 40'd0}, 1'b1, RES_EMPTY},
      '{'{dtq_pkg::KIND_REMOVE, VOL_ONES, 40'd0, 32'd0, 40'd0, 40'd0}, 1'b1, RES_MISSING}
   };

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [KIND_W-1:0]          req_kind;
   logic [VOL_W-1:0]           req_volume_id;
   logic [TIME_W-1:0]          req_creation_time;
   logic signed [RET_W-1:0]    req_retention_seconds;
   logic [TIME_W-1:0]          req_current_time;
   logic [TIME_W-1:0]          req_next_time;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_ok;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_due_valid;
   logic [VOL_W-1:0]           rsp_due_volume;
   logic [TIME_W-1:0]          rsp_earliest_time;
   logic [QCOUNT_W-1:0]        rsp_queued_count;

   logic                       model_used [NSLOTS];
   logic [VOL_W-1:0]           model_vol [NSLOTS];
   logic [TIME_W-1:0]          model_deadline [NSLOTS];
   int                         model_count;

   logic [VOL_W-1:0]           vol_pool [POOL_SIZE];
   vol_result_type             pending_results [$];
   vol_result_type             want;
   int                         error_count = 0;
   int                         quiet_cycles = 0;
   int                         send_gap_pct;
   int                         recv_stall_pct;
   logic                       hold_go;

   due_time_task_queue_top u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic vol_result_type predict_result(input vol_op_type op);
      vol_result_type    r;
      logic [TIME_W:0]   total;
      logic [TIME_W-1:0] deadline;
      int                i;
      int                hit;
      int                free_slot;
      int                best;
      r = '0;
      hit = -1;
      free_slot = -1;
      best = -1;
      for (i = NSLOTS - 1; i >= 0; i--) begin
         if (model_used[i] && model_vol[i] == op.volume) hit = i;
         if (!model_used[i]) free_slot = i;
      end
      case (op.kind)
         dtq_pkg::KIND_ADD: begin
            if ($signed(op.retention) <= 0) begin
               r.ok = 1'b1;
               r.status = dtq_pkg::STAT_FOREVER;
            end else begin
               total = {1'b0, op.created} + {9'd0, op.retention};
               deadline = total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];
               if (hit >= 0) begin
                  if (model_deadline[hit] > deadline) model_deadline[hit] = deadline;
                  r.status = dtq_pkg::STAT_KEPT;
               end else if (free_slot < 0) begin
                  r.status = dtq_pkg::STAT_FULL;
               end else begin
                  model_used[free_slot] = 1'b1;
                  model_vol[free_slot] = op.volume;
                  model_deadline[free_slot] = deadline;
                  model_count++;
                  r.ok = 1'b1;
                  r.status = dtq_pkg::STAT_INSERTED;
               end
            end
         end
         dtq_pkg::KIND_REMOVE: begin
            if (hit >= 0) begin
               model_used[hit] = 1'b0;
               model_count--;
               r.ok = 1'b1;
               r.status = dtq_pkg::STAT_REMOVED;
            end else begin
               r.status = dtq_pkg::STAT_NOT_FOUND;
            end
         end
         dtq_pkg::KIND_RESCHED: begin
            if (hit < 0) begin
               r.status = dtq_pkg::STAT_NOT_FOUND;
            end else if (op.next > op.now) begin
               model_deadline[hit] = op.next;
               r.ok = 1'b1;
               r.status = dtq_pkg::STAT_KEPT;
            end else begin
               model_used[hit] = 1'b0;
               model_count--;
               r.ok = 1'b1;
               r.status = dtq_pkg::STAT_DROPPED;
            end
         end
         default: ;
      endcase
      for (i = 0; i < NSLOTS; i++) begin
         if (model_used[i] && (best < 0 || model_deadline[i] < model_deadline[best])) best = i;
      end
      if (best >= 0) begin
         r.volume = model_vol[best];
         r.earliest = model_deadline[best];
         r.due = (op.kind == dtq_pkg::KIND_TICK) && (model_deadline[best] <= op.now);
      end
      r.count = QCOUNT_W'(model_count);
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] rand_time();
      case ($urandom_range(0, 7))
         0: return TIME_W'({$urandom(), $urandom()});
         1: return TIME_MAX - TIME_W'($urandom_range(0, 100));
         default: return TIME_MID + TIME_W'($urandom_range(0, 3000));
      endcase
   endfunction

   function automatic vol_op_type random_op(input int add_pct);
      vol_op_type o;
      int         pick;
      int         share;
      o.kind = dtq_pkg::KIND_TICK;
      o.volume = vol_pool[$urandom_range(0, POOL_SIZE - 1)];
      o.created = rand_time();
      o.retention = RET_W'($urandom_range(1, 2000));
      o.now = rand_time();
      o.next = rand_time();
      pick = $urandom_range(0, 99);
      share = (95 - add_pct) / 3;
      if (pick < add_pct) begin
         o.kind = dtq_pkg::KIND_ADD;
         case ($urandom_range(0, 9))
            0: o.retention = $urandom();
            1: o.retention = RET_W'(-$urandom_range(0, 8));
            default: ;
         endcase
      end else if (pick < add_pct + share) begin
         o.kind = dtq_pkg::KIND_REMOVE;
      end else if (pick < add_pct + 2 * share) begin
         o.kind = dtq_pkg::KIND_RESCHED;
      end else if (pick >= 95) begin
         // noise: any kind, fields anywhere in their range
         o.kind = dtq_pkg::kind_type'(KIND_W'($urandom_range(0, 3)));
         o.volume = {$urandom(), $urandom()};
         o.created = TIME_W'({$urandom(), $urandom()});
         o.retention = $urandom();
      end
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] exp_val,
                                       input logic [63:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         error_count++;
      end
   endfunction

   task automatic issue_op(input vol_op_type op, input logic has_preset,
                           input vol_result_type preset);
      vol_result_type predicted;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = op.kind;
      req_volume_id = op.volume;
      req_creation_time = op.created;
      req_retention_seconds = op.retention;
      req_current_time = op.now;
      req_next_time = op.next;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = predict_result(op);
      pending_results.push_back(has_preset ? preset : predicted);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int gap_pct, input int stall_pct, input int add_pct,
                            input int count);
      int n;
      send_gap_pct = gap_pct;
      recv_stall_pct = stall_pct;
      for (n = 0; n < count; n++) issue_op(random_op(add_pct), 1'b0, NO_RESULT);
      wait_drained();
   endtask

   // result side: random stall plus one long hold-off on request
   initial begin
      logic hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) begin
               rsp_stall = 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall = ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("ok", 64'(want.ok), 64'(rsp_ok));
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("due_valid", 64'(want.due), 64'(rsp_due_valid));
            check_field("due_volume", want.volume, rsp_due_volume);
            check_field("earliest_time", 64'(want.earliest), 64'(rsp_earliest_time));
            check_field("queued_count", 64'(want.count), 64'(rsp_queued_count));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= TIMEOUT_CYCLES) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = dtq_pkg::KIND_TICK;
      req_volume_id = '0;
      req_creation_time = '0;
      req_retention_seconds = '0;
      req_current_time = '0;
      req_next_time = '0;
      hold_go = 1'b0;
      model_count = 0;
      send_gap_pct = 21;
      recv_stall_pct = 85;
      for (k = 0; k < NSLOTS; k++) begin
         model_used[k] = 1'b0;
         model_vol[k] = '0;
         model_deadline[k] = '0;
      end
      vol_pool[0] = '0;
      vol_pool[1] = VOL_ONES;
      for (k = 2; k < POOL_SIZE; k++) vol_pool[k] = {$urandom(), $urandom()};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < NUM_DIRECTED; k++) begin
         issue_op(DIRECTED[k].op, DIRECTED[k].has_preset, DIRECTED[k].preset);
      end

      // long receiver hold-off while the sender keeps offering beats
      hold_go = 1'b1;
      run_phase(21, 85, 60, 310);
      run_phase(85, 21, 30, 310);
      run_phase(0, 0, 45, 310);

      wait_drained();
      repeat (2 * (NSLOTS + 3)) @(negedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
